// ===== design/tiny_cpu_instruction_execute_macros.svh =====
// ----------------------------------------------------------------------------
// tiny_cpu_instruction_execute_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef TINY_CPU_INSTRUCTION_EXECUTE_MACROS_SVH
`define TINY_CPU_INSTRUCTION_EXECUTE_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define TCIE_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Property checked at every rising clock edge, reset included.
`define TCIE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

// ===== design/tcie_pkg.sv =====
// ----------------------------------------------------------------------------
// tcie_pkg
// Constants and types of the tiny CPU instruction execute block.
// ----------------------------------------------------------------------------
package tcie_pkg;

  localparam int REG_COUNT   = 16;
  localparam int REG_IDX_W   = $clog2(REG_COUNT);
  localparam int WORD_W      = 16;
  localparam int INSTR_W     = 20;
  localparam int BYTE_W      = 8;
  localparam int DATA_ADDR_W = 16;
  localparam int DATA_SIZE   = 65536;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 64;

  localparam logic [WORD_W-1:0] PROGRAM_SIZE = 16'd64;
  localparam logic [WORD_W-1:0] HALT_PC      = 16'hFFFF;

  typedef enum logic [3:0] {
    OP_ADD  = 4'h0,
    OP_LW   = 4'h2,
    OP_SW   = 4'h3,
    OP_BEQ  = 4'h4,
    OP_J    = 4'hE,
    OP_HALT = 4'hF
  } opcode_t;

  typedef enum logic {
    ACT_EXEC   = 1'b0,
    ACT_PRESET = 1'b1
  } action_t;

  typedef struct packed {
    logic [WORD_W-1:0]      next_pc;
    logic                   halted;
    logic                   reg_written;
    logic [REG_IDX_W-1:0]   dest_index;
    logic [WORD_W-1:0]      dest_value;
    logic                   mem_written;
    logic [DATA_ADDR_W-1:0] mem_address;
    logic [BYTE_W-1:0]      mem_byte;
    logic                   is_load;
  } result_t;

endpackage

// ===== design/tiny_cpu_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// tiny_cpu_instruction_execute
// Executes one instruction or register preset per item on a 16 x 16-bit
// register machine with a 64 KiB byte data store.
// ----------------------------------------------------------------------------
// Input channel s_axis: tuser is the action (execute or preset), tdata holds
// the instruction word and the preset index and value. Output channel m_axis
// carries one result item per input item: next PC, halted flag, register
// write and data store write reports.
// An item accepted at the input loads the read stage; the execute logic then
// loads the output register from it when that register is free or being
// emptied. Throughput: one item per cycle, as long as m_axis_tready stays
// high; register operands are forwarded from the output register and the
// last retired write, so dependent items need no bubble.
// Register writes retire when the result item leaves; the register file has
// two read ports and one write port, the data store one read and one write.
// Reset clears PC, register file valid bits and pipeline, then sweeps the
// data store to zero one byte per cycle: s_axis_tready stays low until the
// sweep is done. A stalled receiver holds the result; up to one more item
// is taken into the read stage, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module tiny_cpu_instruction_execute
  import tcie_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // instr_word[19:0], preset_index[23:20], preset_value[39:24]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // action
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // next_pc[15:0], halted[16], reg_written[17], dest_index[21:18],
  // dest_value[37:22], mem_written[38], mem_address[54:39], mem_byte[62:55]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic                   clearing;
  logic [DATA_ADDR_W-1:0] clr_addr;
  logic [BYTE_W-1:0]      dmem [DATA_SIZE];
  logic [BYTE_W-1:0]      dmem_q;

  logic [WORD_W-1:0]      rf [REG_COUNT];
  logic [REG_COUNT-1:0]   rf_valid;
  logic [WORD_W-1:0]      rf_qa;
  logic [WORD_W-1:0]      rf_qb;

  logic                   s1_valid;
  action_t                s1_action;
  logic [INSTR_W-1:0]     s1_instr;
  logic [REG_IDX_W-1:0]   s1_pidx;
  logic [WORD_W-1:0]      s1_pval;
  logic [REG_IDX_W-1:0]   s1_ra;
  logic [REG_IDX_W-1:0]   s1_rb;

  logic [WORD_W-1:0]      pc;
  logic                   s2_valid;
  result_t                s2;

  logic                   last_valid;
  logic [REG_IDX_W-1:0]   last_idx;
  logic [WORD_W-1:0]      last_val;

  logic                   in_acc;
  logic                   out_acc;
  logic                   s1_adv;
  logic [INSTR_W-1:0]     in_instr;
  logic [REG_IDX_W-1:0]   rd_a;
  logic [REG_IDX_W-1:0]   rd_b;
  logic [WORD_W-1:0]      wb_value;
  logic [WORD_W-1:0]      opa;
  logic [WORD_W-1:0]      opb;
  logic [DATA_ADDR_W-1:0] ea;
  result_t                r;

  function automatic logic is_halted(input logic [WORD_W-1:0] p);
    return (p == HALT_PC) || (p >= PROGRAM_SIZE);
  endfunction

  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_acc       = s2_valid & m_axis_tready;
  assign s1_adv        = s1_valid & (~s2_valid | m_axis_tready);
  assign s_axis_tready = ~clearing & (~s1_valid | s1_adv);
  assign m_axis_tvalid = s2_valid;

  assign in_instr = s_axis_tdata[19:0];
  assign rd_a     = in_instr[11:8];
  assign rd_b     = (opcode_t'(in_instr[19:16]) == OP_ADD) ? in_instr[7:4] : in_instr[15:12];

  assign wb_value = s2.is_load ? {{(WORD_W-BYTE_W){1'b0}}, dmem_q} : s2.dest_value;

  assign m_axis_tdata = {1'b0, s2.mem_byte, s2.mem_address, s2.mem_written, wb_value,
                         s2.dest_index, s2.reg_written, s2.halted, s2.next_pc};

  // operand forwarding: output register first, then last retired write
  always_comb begin
    opa = rf_qa;
    opb = rf_qb;
    if (last_valid && last_idx == s1_ra) opa = last_val;
    if (last_valid && last_idx == s1_rb) opb = last_val;
    if (s2_valid && s2.reg_written && s2.dest_index == s1_ra) opa = wb_value;
    if (s2_valid && s2.reg_written && s2.dest_index == s1_rb) opb = wb_value;
  end

  always_comb begin
    logic [BYTE_W-1:0] imm;
    logic [WORD_W-1:0] simm;
    logic [WORD_W-1:0] pc_op;
    logic [WORD_W-1:0] pc_new;
    opcode_t           op;
    imm    = s1_instr[7:0];
    simm   = {{(WORD_W-BYTE_W){imm[BYTE_W-1]}}, imm};
    op     = opcode_t'(s1_instr[19:16]);
    ea     = opa + simm;
    r      = '0;
    pc_op  = pc;
    pc_new = pc;
    if (s1_action == ACT_PRESET) begin
      r.reg_written = 1'b1;
      r.dest_index  = s1_pidx;
      r.dest_value  = s1_pval;
    end else if (!is_halted(pc)) begin
      unique case (op)
        OP_ADD: begin
          r.reg_written = 1'b1;
          r.dest_index  = s1_instr[15:12];
          r.dest_value  = opa + opb;
        end
        OP_LW: begin
          r.reg_written = 1'b1;
          r.dest_index  = s1_instr[15:12];
          r.is_load     = 1'b1;
        end
        OP_SW: begin
          r.mem_written = 1'b1;
          r.mem_address = ea;
          r.mem_byte    = opb[BYTE_W-1:0];
        end
        OP_BEQ: begin
          if (opa == opb) pc_op = pc + simm;
        end
        OP_J:    pc_op = s1_instr[15:0] - 16'd1;
        OP_HALT: pc_op = HALT_PC;
        default: pc_op = pc;
      endcase
      pc_new = (pc_op == HALT_PC) ? pc_op : pc_op + 16'd1;
    end
    r.next_pc = pc_new;
    r.halted  = is_halted(pc_new);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clr_addr   <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      pc         <= '0;
      rf_valid   <= '0;
      last_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == DATA_ADDR_W'(DATA_SIZE - 1)) clearing <= 1'b0;
      end
      if (in_acc)      s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
      if (s1_adv)       s2_valid <= 1'b1;
      else if (out_acc) s2_valid <= 1'b0;
      if (s1_adv) pc <= r.next_pc;
      if (out_acc && s2.reg_written) begin
        rf_valid[s2.dest_index] <= 1'b1;
        last_valid              <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action <= action_t'(s_axis_tuser);
      s1_instr  <= in_instr;
      s1_pidx   <= s_axis_tdata[23:20];
      s1_pval   <= s_axis_tdata[39:24];
      s1_ra     <= rd_a;
      s1_rb     <= rd_b;
    end
    if (s1_adv) s2 <= r;
    if (out_acc && s2.reg_written) begin
      last_idx <= s2.dest_index;
      last_val <= wb_value;
    end
  end

  // register file: two read ports, one write port
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rf_qa <= rf_valid[rd_a] ? rf[rd_a] : '0;
      rf_qb <= rf_valid[rd_b] ? rf[rd_b] : '0;
    end
    if (out_acc && s2.reg_written) rf[s2.dest_index] <= wb_value;
  end

  // data store: one write port, one read port
  always_ff @(posedge clk) begin
    if (clearing) begin
      dmem[clr_addr] <= '0;
    end else if (s1_adv && r.mem_written) begin
      dmem[ea] <= r.mem_byte;
    end
    if (s1_adv && r.is_load) dmem_q <= dmem[ea];
  end

endmodule

// ===== design/tcie_checker.sv =====
// ----------------------------------------------------------------------------
// tcie_checker
// Port-level checks of the tiny CPU instruction execute block.
// ----------------------------------------------------------------------------
`include "tiny_cpu_instruction_execute_macros.svh"

module tcie_checker
  import tcie_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic       in_acc;
  logic       out_acc;
  logic [2:0] occ;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;

  // items inside the block
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + {2'b0, in_acc} - {2'b0, out_acc};
    end
  end

  `TCIE_ASSERT(a_occ_bound, clk, rst, occ <= 3'd2)
  `TCIE_ASSERT(a_out_has_item, clk, rst, m_axis_tvalid |-> occ != 3'd0)
  `TCIE_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `TCIE_ASSERT_ALWAYS(a_clear_after_reset, clk, rst |=> !s_axis_tready)

endmodule

bind tiny_cpu_instruction_execute tcie_checker u_tcie_checker (.*);

// ===== tb/tb_tiny_cpu_instruction_execute.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tiny_cpu_instruction_execute
// Drives instruction and preset items into the tiny CPU execute block. A
// shadow machine keeps its own registers, PC and data store to predict every
// result item. Directed tests exercise each opcode but halt, and edge cases,
// then a long random program runs without halting, and the run ends with one halt.
// ----------------------------------------------------------------------------
module tb_tiny_cpu_instruction_execute;
  import tcie_pkg::*;

  localparam logic [3:0] OP_UNUSED_1 = 4'h1;
  localparam logic [3:0] OP_UNUSED_D = 4'hD;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        halted;
    logic        reg_written;
    logic [3:0]  dest_index;
    logic [15:0] dest_value;
    logic        mem_written;
    logic [15:0] mem_address;
    logic [7:0]  mem_byte;
  } cpu_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tready = 1'b0;
  logic s_axis_tready;
  logic m_axis_tvalid;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // shadow machine
  bit [15:0] gpr [REG_COUNT];
  bit [15:0] cpu_pc;
  bit [7:0]  dmem [DATA_SIZE];

  cpu_step_t expected_steps[$];
  int fail_count = 0;
  bit send_idle = 1'b1;
  bit take_idle = 1'b1;

  tiny_cpu_instruction_execute dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_tdata),
    .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic bit is_stopped(logic [15:0] pc);
    return pc == HALT_PC || pc >= PROGRAM_SIZE;
  endfunction

  function automatic logic [19:0] instr(logic [3:0] op, logic [3:0] rd, logic [3:0] rs,
                                        logic [7:0] low);
    return {op, rd, rs, low};
  endfunction

  // PC after executing w on the current shadow state
  function automatic logic [15:0] next_pc_of(logic [19:0] w);
    logic [15:0] pc;
    pc = cpu_pc;
    case (opcode_t'(w[19:16]))
      OP_BEQ: if (gpr[w[15:12]] == gpr[w[11:8]]) pc = pc + {{8{w[7]}}, w[7:0]};
      OP_J: pc = w[15:0] - 16'd1;
      OP_HALT: pc = HALT_PC;
      default: ;
    endcase
    if (pc != HALT_PC) pc = pc + 16'd1;
    return pc;
  endfunction

  task automatic advance_machine(logic act, logic [19:0] w, logic [3:0] pi, logic [15:0] pv);
    cpu_step_t e;
    logic [15:0] ea;
    logic [15:0] npc;
    e = '0;
    if (act == ACT_PRESET) begin
      gpr[pi] = pv;
      e.reg_written = 1'b1;
      e.dest_index = pi;
      e.dest_value = pv;
    end else if (!is_stopped(cpu_pc)) begin
      ea = gpr[w[11:8]] + {{8{w[7]}}, w[7:0]};
      npc = next_pc_of(w);
      case (opcode_t'(w[19:16]))
        OP_ADD: begin
          e.reg_written = 1'b1;
          e.dest_index = w[15:12];
          e.dest_value = gpr[w[11:8]] + gpr[w[7:4]];
        end
        OP_LW: begin
          e.reg_written = 1'b1;
          e.dest_index = w[15:12];
          e.dest_value = {8'h00, dmem[ea]};
        end
        OP_SW: begin
          e.mem_written = 1'b1;
          e.mem_address = ea;
          e.mem_byte = gpr[w[15:12]][7:0];
          dmem[ea] = e.mem_byte;
        end
        default: ;
      endcase
      if (e.reg_written) gpr[e.dest_index] = e.dest_value;
      cpu_pc = npc;
    end
    e.next_pc = cpu_pc;
    e.halted = is_stopped(cpu_pc);
    expected_steps.push_back(e);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_item(logic act, logic [19:0] w, logic [3:0] pi, logic [15:0] pv);
    int gap;
    gap = send_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {pv, pi, w};
    s_tuser <= act;
    do @(posedge clk); while (!s_axis_tready);
    advance_machine(act, w, pi, pv);
    @(negedge clk);
  endtask

  task automatic exec_word(logic [19:0] w);
    send_item(ACT_EXEC, w, 4'($urandom), 16'($urandom));
  endtask

  task automatic preset(logic [3:0] idx, logic [15:0] val);
    send_item(ACT_PRESET, 20'($urandom), idx, val);
  endtask

  function automatic logic [3:0] pick_reg();
    return $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom);
  endfunction

  function automatic logic [19:0] random_instr();
    int r;
    logic [3:0] op;
    logic [3:0] rd;
    logic [3:0] rs;
    logic [7:0] low;
    r = $urandom_range(0, 99);
    rd = pick_reg();
    rs = pick_reg();
    low = {pick_reg(), 4'($urandom)};
    if (r < 25) return instr(OP_ADD, rd, rs, low);
    if (r < 45) return instr(OP_LW, rd, rs, low);
    if (r < 65) return instr(OP_SW, rd, rs, low);
    if (r < 80) begin
      if ($urandom_range(0, 2) == 0) rs = rd;
      if ($urandom_range(0, 1)) low = 8'(int'($urandom_range(0, 62)) - int'(cpu_pc));
      return instr(OP_BEQ, rd, rs, low);
    end
    if (r < 90) begin
      if ($urandom_range(0, 4) == 0) return {OP_J, 16'($urandom)};
      return {OP_J, 16'($urandom_range(1, PROGRAM_SIZE - 1))};
    end
    do op = 4'($urandom); while (op inside {OP_ADD, OP_LW, OP_SW, OP_BEQ, OP_J, OP_HALT});
    return {op, 16'($urandom)};
  endfunction

  task automatic check_field(string name, logic [15:0] exp, logic [15:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, actual %0h", name, exp, act);
      fail_count++;
    end
  endtask

  // result side: random stalls, compare against oldest prediction
  initial begin
    int w;
    cpu_step_t got;
    cpu_step_t exp;
    forever begin
      @(negedge clk);
      w = take_idle ? $urandom_range(0, 13) : 0;
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got.next_pc = m_axis_tdata[15:0];
      got.halted = m_axis_tdata[16];
      got.reg_written = m_axis_tdata[17];
      got.dest_index = m_axis_tdata[21:18];
      got.dest_value = m_axis_tdata[37:22];
      got.mem_written = m_axis_tdata[38];
      got.mem_address = m_axis_tdata[54:39];
      got.mem_byte = m_axis_tdata[62:55];
      if (expected_steps.size() == 0) begin
        $error("result item with no prediction pending: %h", m_axis_tdata);
        fail_count++;
      end else begin
        exp = expected_steps.pop_front();
        check_field("next_pc", exp.next_pc, got.next_pc);
        check_field("halted", 16'(exp.halted), 16'(got.halted));
        check_field("reg_written", 16'(exp.reg_written), 16'(got.reg_written));
        check_field("dest_index", 16'(exp.dest_index), 16'(got.dest_index));
        check_field("dest_value", exp.dest_value, got.dest_value);
        check_field("mem_written", 16'(exp.mem_written), 16'(got.mem_written));
        check_field("mem_address", exp.mem_address, got.mem_address);
        check_field("mem_byte", 16'(exp.mem_byte), 16'(got.mem_byte));
      end
    end
  end

  task automatic test_add();
    preset(4'd15, 16'hFFFF);
    preset(4'd2, 16'h0001);
    preset(4'd3, 16'h8000);
    exec_word(instr(OP_ADD, 4'd4, 4'd15, 8'h20));  // wraps to 0
    exec_word(instr(OP_ADD, 4'd5, 4'd4, 8'hF0));   // uses previous result
    exec_word(instr(OP_ADD, 4'd5, 4'd5, 8'h50));
    exec_word(instr(OP_ADD, 4'd6, 4'd3, 8'h30));
  endtask

  task automatic test_load_store();
    exec_word(instr(OP_SW, 4'd15, 4'd6, 8'hFF));   // address wraps to 0xFFFF
    exec_word(instr(OP_LW, 4'd7, 4'd6, 8'hFF));    // load right after store
    exec_word(instr(OP_LW, 4'd8, 4'd2, 8'h7F));    // never written
    exec_word(instr(OP_SW, 4'd5, 4'd2, 8'h7F));
    exec_word(instr(OP_LW, 4'd9, 4'd2, 8'h7F));
  endtask

  task automatic test_branch();
    exec_word(instr(OP_BEQ, 4'd4, 4'd6, 8'h03));   // taken forward
    exec_word(instr(OP_BEQ, 4'd15, 4'd2, 8'h80));  // not taken
    exec_word(instr(OP_BEQ, 4'd7, 4'd7, 8'hFC));   // taken backward
  endtask

  task automatic test_jump();
    exec_word({OP_J, 16'h0030});
    exec_word({OP_J, 16'h0020});
  endtask

  task automatic test_unknown_opcode();
    exec_word({OP_UNUSED_1, 16'h0000});
    exec_word({OP_UNUSED_D, 16'hFFFF});
  endtask

  task automatic test_random_program(int count);
    logic [19:0] w;
    int tries;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        send_idle = $urandom_range(0, 3) != 0;
        take_idle = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 6) == 0) begin
        preset(4'($urandom),
               $urandom_range(0, 1) ? 16'($urandom_range(0, 31)) : 16'($urandom));
      end else begin
        tries = 0;
        do begin
          w = random_instr();
          tries++;
        end while (is_stopped(next_pc_of(w)) && tries < 8);
        if (is_stopped(next_pc_of(w))) w = {OP_J, 16'($urandom_range(1, PROGRAM_SIZE - 1))};
        exec_word(w);
      end
    end
    send_idle = 1'b1;
    take_idle = 1'b1;
  endtask

  // only one halt per run: the way into it is drawn at random
  task automatic test_halt();
    logic [3:0] r;
    r = pick_reg();
    case ($urandom_range(0, 4))
      0: exec_word({OP_HALT, 16'($urandom)});
      1: exec_word({OP_J, 16'h0000});
      2: exec_word(instr(OP_BEQ, r, r, 8'(-(int'(cpu_pc) + 1))));
      3: exec_word({OP_J, 16'($urandom_range(PROGRAM_SIZE, 16'hFFFF))});
      default: begin
        exec_word({OP_J, 16'(PROGRAM_SIZE - 1)});
        exec_word(instr(OP_ADD, pick_reg(), pick_reg(), 8'($urandom)));
      end
    endcase
    for (int i = 0; i < 12; i++) begin
      if ($urandom_range(0, 2) == 0) preset(4'($urandom), 16'($urandom));
      else exec_word(20'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_add();
    test_load_store();
    test_branch();
    test_jump();
    test_unknown_opcode();
    test_random_program(1250);
    test_halt();
    s_tvalid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
